/* rtl/orl_pkg.sv */
package orl_pkg;

  localparam int COORD_BITS     = 13;
  localparam int SIZE_BITS      = 10;
  localparam int TRIG_FRAC_BITS = 14;
  localparam int ANGLE_BITS     = 16;

  // signed trig value, range -2^T .. 2^T
  localparam int TRIG_BITS = TRIG_FRAC_BITS + 2;
  // unsigned quarter sine entry, range 0 .. 2^T
  localparam int QSIN_BITS = TRIG_FRAC_BITS + 1;
  localparam int QSIN_N    = 91;
  // centre difference in Q1: 2*x + w spans COORD_BITS+2 signed, diff one more
  localparam int DIFF_BITS = COORD_BITS + 3;
  // dot products of two terms
  localparam int DOT_BITS  = 2 * TRIG_BITS + 1;
  localparam int DIST_BITS = DIFF_BITS + TRIG_BITS + 1;
  // extents of both rectangles summed, then the width of the scaled compare
  localparam int EXT_BITS  = SIZE_BITS + DOT_BITS + 2;
  localparam int CMP_BITS  = DIST_BITS + TRIG_FRAC_BITS + 2;

  // angle reduction: q = (a * RECIP) >> RECIP_SHIFT is floor(a/360) or one below
  localparam int          RECIP_SHIFT = 24;
  localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / 360;
  localparam int          QUOT_BITS   = 8;
  localparam int          DEG_BITS    = 9;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef logic [QSIN_N*QSIN_BITS-1:0] qsin_tbl_t;

  // quarter sine table, sin(k deg) for k = 0..90, rounded to QT
  function automatic qsin_tbl_t build_qsin();
    qsin_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    tbl = '0;
    for (int k = 0; k < QSIN_N; k++) begin
      x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      // alternating Taylor terms, each derived from the one before
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
      sum = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      if (sum > (64'd1 << TRIG_FRAC_BITS)) begin
        sum = 64'd1 << TRIG_FRAC_BITS;
      end
      tbl[k*QSIN_BITS +: QSIN_BITS] = sum[QSIN_BITS-1:0];
    end
    return tbl;
  endfunction

  localparam qsin_tbl_t QSIN_TBL = build_qsin();

endpackage

/* rtl/orl_sincos.sv */
module orl_sincos (
  input  logic [orl_pkg::DEG_BITS-1:0]         deg,
  output logic signed [orl_pkg::TRIG_BITS-1:0] sin_v,
  output logic signed [orl_pkg::TRIG_BITS-1:0] cos_v
);
  import orl_pkg::*;

  logic [DEG_BITS-1:0]  ks;
  logic [DEG_BITS-1:0]  kc;
  logic                 ns;
  logic                 nc;
  logic [QSIN_BITS-1:0] qs;
  logic [QSIN_BITS-1:0] qc;

  // fold the angle into the first quadrant, keep the signs
  always_comb begin
    if (deg < DEG_BITS'(90)) begin
      ks = deg;                   ns = 1'b0;
      kc = DEG_BITS'(90) - deg;   nc = 1'b0;
    end else if (deg < DEG_BITS'(180)) begin
      ks = DEG_BITS'(180) - deg;  ns = 1'b0;
      kc = deg - DEG_BITS'(90);   nc = 1'b1;
    end else if (deg < DEG_BITS'(270)) begin
      ks = deg - DEG_BITS'(180);  ns = 1'b1;
      kc = DEG_BITS'(270) - deg;  nc = 1'b1;
    end else begin
      ks = DEG_BITS'(360) - deg;  ns = 1'b1;
      kc = deg - DEG_BITS'(270);  nc = 1'b0;
    end
  end

  assign qs = QSIN_TBL[ks[6:0]*QSIN_BITS +: QSIN_BITS];
  assign qc = QSIN_TBL[kc[6:0]*QSIN_BITS +: QSIN_BITS];

  assign sin_v = ns ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
  assign cos_v = nc ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

endmodule

/* rtl/oriented_rect_overlap_test.sv */
// channel | handshake            | payload
// in      | in_valid / in_ready  | first_/second_ x, y, width, height, angle
// out     | out_valid / out_ready | overlap
//
// Five register stages: angle quotient, sin/cos ROM, axis dot products,
// extents, interval compare; one test per cycle while out is not stalled.
// The rate is set by the single shared stall enable of the pipeline.
// Reset (rst, synchronous) clears the stage valid bits only.
// A stall at out freezes every stage; nothing is lost or repeated.
module oriented_rect_overlap_test (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [orl_pkg::COORD_BITS-1:0] first_x,
  input  logic signed [orl_pkg::COORD_BITS-1:0] first_y,
  input  logic signed [orl_pkg::COORD_BITS-1:0] second_x,
  input  logic signed [orl_pkg::COORD_BITS-1:0] second_y,
  input  logic [orl_pkg::SIZE_BITS-1:0]         first_width,
  input  logic [orl_pkg::SIZE_BITS-1:0]         first_height,
  input  logic [orl_pkg::SIZE_BITS-1:0]         second_width,
  input  logic [orl_pkg::SIZE_BITS-1:0]         second_height,
  input  logic [orl_pkg::ANGLE_BITS-1:0]        first_angle,
  input  logic [orl_pkg::ANGLE_BITS-1:0]        second_angle,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  overlap
);
  import orl_pkg::*;

  localparam int PROD_BITS = ANGLE_BITS + 16;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: angle quotient, centre differences
  logic                         v1;
  logic [QUOT_BITS-1:0]         q1a, q2a;
  logic [ANGLE_BITS-1:0]        a1, a2;
  logic signed [DIFF_BITS-1:0]  dx1, dy1;
  logic [SIZE_BITS-1:0]         w1a, h1a, w2a, h2a;
  logic [PROD_BITS-1:0]         pa1, pa2;
  logic signed [DIFF_BITS-1:0]  c1x, c1y, c2x, c2y;

  assign pa1 = PROD_BITS'(first_angle) * PROD_BITS'(RECIP);
  assign pa2 = PROD_BITS'(second_angle) * PROD_BITS'(RECIP);
  assign c1x = (DIFF_BITS'(first_x) <<< 1) + $signed(DIFF_BITS'(first_width));
  assign c1y = (DIFF_BITS'(first_y) <<< 1) + $signed(DIFF_BITS'(first_height));
  assign c2x = (DIFF_BITS'(second_x) <<< 1) + $signed(DIFF_BITS'(second_width));
  assign c2y = (DIFF_BITS'(second_y) <<< 1) + $signed(DIFF_BITS'(second_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1a <= pa1[RECIP_SHIFT +: QUOT_BITS];
      q2a <= pa2[RECIP_SHIFT +: QUOT_BITS];
      a1  <= first_angle;
      a2  <= second_angle;
      dx1 <= c2x - c1x;
      dy1 <= c2y - c1y;
      w1a <= first_width;
      h1a <= first_height;
      w2a <= second_width;
      h2a <= second_height;
    end
  end

  // stage 2: finish modulo 360, sin/cos lookup
  logic [ANGLE_BITS-1:0]        r1, r2;
  logic [DEG_BITS-1:0]          deg1, deg2;
  logic signed [TRIG_BITS-1:0]  s1n, c1n, s2n, c2n;

  assign r1   = a1 - ANGLE_BITS'(q1a) * ANGLE_BITS'(360);
  assign r2   = a2 - ANGLE_BITS'(q2a) * ANGLE_BITS'(360);
  assign deg1 = (r1 >= ANGLE_BITS'(360)) ? DEG_BITS'(r1 - ANGLE_BITS'(360)) : DEG_BITS'(r1);
  assign deg2 = (r2 >= ANGLE_BITS'(360)) ? DEG_BITS'(r2 - ANGLE_BITS'(360)) : DEG_BITS'(r2);

  orl_sincos u_sc1 (.deg(deg1), .sin_v(s1n), .cos_v(c1n));
  orl_sincos u_sc2 (.deg(deg2), .sin_v(s2n), .cos_v(c2n));

  logic                         v2;
  logic signed [TRIG_BITS-1:0]  s1, c1, s2, c2;
  logic signed [DIFF_BITS-1:0]  dx2, dy2;
  logic [SIZE_BITS-1:0]         w1b, h1b, w2b, h2b;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1  <= s1n;
      c1  <= c1n;
      s2  <= s2n;
      c2  <= c2n;
      dx2 <= dx1;
      dy2 <= dy1;
      w1b <= w1a;
      h1b <= h1a;
      w2b <= w2a;
      h2b <= h2a;
    end
  end

  // axis lanes: edge directions, zero when the edge has no length
  logic signed [TRIG_BITS-1:0] ax [4];
  logic signed [TRIG_BITS-1:0] ay [4];

  assign ax[0] = (w1b != '0) ? c1 : '0;
  assign ay[0] = (w1b != '0) ? s1 : '0;
  assign ax[1] = (h1b != '0) ? s1 : '0;
  assign ay[1] = (h1b != '0) ? -c1 : '0;
  assign ax[2] = (w2b != '0) ? c2 : '0;
  assign ay[2] = (w2b != '0) ? s2 : '0;
  assign ax[3] = (h2b != '0) ? s2 : '0;
  assign ay[3] = (h2b != '0) ? -c2 : '0;

  // stage 3: dot products of both frames and the centre gap with each axis
  logic                         v3;
  logic signed [DOT_BITS-1:0]   pa [4];
  logic signed [DOT_BITS-1:0]   pb [4];
  logic signed [DOT_BITS-1:0]   qa [4];
  logic signed [DOT_BITS-1:0]   qb [4];
  logic signed [DIST_BITS-1:0]  dd3 [4];
  logic [SIZE_BITS-1:0]         w1c, h1c, w2c, h2c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        pa[k]  <= DOT_BITS'(c1 * ax[k]) + DOT_BITS'(s1 * ay[k]);
        pb[k]  <= DOT_BITS'(c1 * ay[k]) - DOT_BITS'(s1 * ax[k]);
        qa[k]  <= DOT_BITS'(c2 * ax[k]) + DOT_BITS'(s2 * ay[k]);
        qb[k]  <= DOT_BITS'(c2 * ay[k]) - DOT_BITS'(s2 * ax[k]);
        dd3[k] <= DIST_BITS'(dx2 * ax[k]) + DIST_BITS'(dy2 * ay[k]);
      end
      w1c <= w1b;
      h1c <= h1b;
      w2c <= w2b;
      h2c <= h2b;
    end
  end

  // stage 4: half extents of both rectangles on each axis, summed
  logic                         v4;
  logic [EXT_BITS-1:0]          ext [4];
  logic signed [DIST_BITS-1:0]  dd4 [4];

  function automatic logic [DOT_BITS-1:0] mag(input logic signed [DOT_BITS-1:0] v);
    return v[DOT_BITS-1] ? DOT_BITS'(-v) : DOT_BITS'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        ext[k] <= EXT_BITS'(w1c) * EXT_BITS'(mag(pa[k]))
                + EXT_BITS'(h1c) * EXT_BITS'(mag(pb[k]))
                + EXT_BITS'(w2c) * EXT_BITS'(mag(qa[k]))
                + EXT_BITS'(h2c) * EXT_BITS'(mag(qb[k]));
        dd4[k] <= dd3[k];
      end
    end
  end

  // stage 5: overlap on an axis when the scaled gap lies within the extents
  logic [3:0]                  hit;
  logic signed [CMP_BITS-1:0]  ds [4];
  logic signed [CMP_BITS-1:0]  es [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ds[k]  = CMP_BITS'(dd4[k]) <<< TRIG_FRAC_BITS;
      es[k]  = $signed(CMP_BITS'(ext[k]));
      hit[k] = (ds[k] <= es[k]) && (-ds[k] <= es[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= &hit;
    end
  end

endmodule

/* rtl/orl_checker.sv */
module orl_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic overlap
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(overlap))
    else $error("result changed while stalled");

  // input side stalls exactly when a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");

  // pipeline empties at reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // in_valid, in_ready and out_valid are always known out of reset
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({in_valid, in_ready, out_valid}))
    else $error("handshake signal unknown");

endmodule

bind oriented_rect_overlap_test orl_checker u_orl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .overlap(overlap)
);

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import orl_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [COORD_BITS-1:0] first_x, first_y, second_x, second_y;
  logic [SIZE_BITS-1:0] first_width, first_height, second_width, second_height;
  logic [ANGLE_BITS-1:0] first_angle, second_angle;
  logic out_valid;
  logic out_ready;
  logic overlap;

  typedef struct {
    logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
    logic [SIZE_BITS-1:0]         w1, h1, w2, h2;
    logic [ANGLE_BITS-1:0]        a1, a2;
  } rect_pair_t;

  typedef struct {
    longint cx, cy;
    longint ox[4], oy[4];
    longint ux, uy, vx, vy;
  } obox_t;

  typedef bit bool_near_t;

  // sine table for 0..90 degrees in QT, built independently
  longint quarter_sine[91];

  function automatic longint qsine(int k);
    longint unsigned pi30, x, x2, term, sum;
    pi30 = 64'd3373259426;
    x = (longint'(k) * pi30 + 90) / 180;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    sum = (sum + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    if (sum > (64'd1 << TRIG_FRAC_BITS)) sum = 64'd1 << TRIG_FRAC_BITS;
    return longint'(sum);
  endfunction

  function automatic obox_t make_box(logic signed [COORD_BITS-1:0] x,
                                     logic signed [COORD_BITS-1:0] y,
                                     logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h,
                                     logic [ANGLE_BITS-1:0] ang);
    obox_t b;
    int deg;
    longint s, c, lw, lh, hx, hy;
    int sx[4];
    int sy[4];
    sx = '{-1, 1, 1, -1};
    sy = '{-1, -1, 1, 1};
    deg = int'(ang) % 360;
    lw = longint'(w);
    lh = longint'(h);
    if (deg < 90) begin
      s = quarter_sine[deg]; c = quarter_sine[90 - deg];
    end else if (deg < 180) begin
      s = quarter_sine[180 - deg]; c = -quarter_sine[deg - 90];
    end else if (deg < 270) begin
      s = -quarter_sine[deg - 180]; c = -quarter_sine[270 - deg];
    end else begin
      s = -quarter_sine[360 - deg]; c = quarter_sine[deg - 270];
    end
    b.cx = 2 * longint'(x) + lw;
    b.cy = 2 * longint'(y) + lh;
    for (int i = 0; i < 4; i++) begin
      hx = sx[i] * lw;
      hy = sy[i] * lh;
      b.ox[i] = hx * c - hy * s;
      b.oy[i] = hx * s + hy * c;
    end
    b.ux = (w != 0) ? c : 0;
    b.uy = (w != 0) ? s : 0;
    b.vx = (h != 0) ? s : 0;
    b.vy = (h != 0) ? -c : 0;
    return b;
  endfunction

  function automatic bit axis_hit(obox_t p, obox_t q, longint ax, longint ay);
    longint lo1, hi1, lo2, hi2, pr, d, lim;
    lo1 = p.ox[0] * ax + p.oy[0] * ay; hi1 = lo1;
    lo2 = q.ox[0] * ax + q.oy[0] * ay; hi2 = lo2;
    for (int i = 1; i < 4; i++) begin
      pr = p.ox[i] * ax + p.oy[i] * ay;
      if (pr < lo1) lo1 = pr;
      if (pr > hi1) hi1 = pr;
      pr = q.ox[i] * ax + q.oy[i] * ay;
      if (pr < lo2) lo2 = pr;
      if (pr > hi2) hi2 = pr;
    end
    lim = 64'sd1 <<< (61 - TRIG_FRAC_BITS);
    d = (q.cx - p.cx) * ax + (q.cy - p.cy) * ay;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    d = d * (64'sd1 <<< TRIG_FRAC_BITS);
    if (hi1 - lo2 < d) return 0;
    if (d < lo1 - hi2) return 0;
    return 1;
  endfunction

  function automatic bit predict_overlap(rect_pair_t t);
    obox_t r1, r2;
    r1 = make_box(t.x1, t.y1, t.w1, t.h1, t.a1);
    r2 = make_box(t.x2, t.y2, t.w2, t.h2, t.a2);
    return axis_hit(r1, r2, r1.ux, r1.uy) && axis_hit(r1, r2, r1.vx, r1.vy) &&
           axis_hit(r1, r2, r2.ux, r2.uy) && axis_hit(r1, r2, r2.vx, r2.vy);
  endfunction

  // holds expected overlap flags in order
  class overlap_board;
    bit pending[$];
    int errors;
    int hits;
    int checked;

    function void note_test(rect_pair_t t);
      pending.push_back(predict_overlap(t));
    endfunction

    function void check_flag(logic got);
      bit exp_flag;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result overlap=%0b", $time, got);
        errors++;
        return;
      end
      exp_flag = pending.pop_front();
      checked++;
      if (got === 1'b1) hits++;
      if (got !== exp_flag) begin
        $display("%0t: overlap mismatch expected %0b actual %0b", $time, exp_flag, got);
        errors++;
      end
    endfunction
  endclass

  overlap_board board;
  rect_pair_t stim[$];
  bit gaps_on;
  bit sending_done;
  longint cycles = 0;

  oriented_rect_overlap_test dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle counter for the watchdog
  always @(posedge clk) cycles <= cycles + 1;

  // apply one rectangle pair and wait for acceptance
  task automatic send_pair(rect_pair_t t);
    while (gaps_on && $urandom_range(99) < 14) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    first_x <= t.x1; first_y <= t.y1; second_x <= t.x2; second_y <= t.y2;
    first_width <= t.w1; first_height <= t.h1;
    second_width <= t.w2; second_height <= t.h2;
    first_angle <= t.a1; second_angle <= t.a2;
    do @(posedge clk); while (!in_ready);
    board.note_test(t);
  endtask

  function automatic rect_pair_t rand_pair(bool_near_t near);
    rect_pair_t t;
    int mode;
    mode = $urandom_range(9);
    t.x1 = COORD_BITS'($urandom); t.y1 = COORD_BITS'($urandom);
    t.x2 = COORD_BITS'($urandom); t.y2 = COORD_BITS'($urandom);
    t.w1 = SIZE_BITS'($urandom); t.h1 = SIZE_BITS'($urandom);
    t.w2 = SIZE_BITS'($urandom); t.h2 = SIZE_BITS'($urandom);
    t.a1 = (mode < 5) ? ANGLE_BITS'($urandom_range(359)) : ANGLE_BITS'($urandom);
    t.a2 = (mode % 2) ? ANGLE_BITS'($urandom_range(359)) : ANGLE_BITS'($urandom);
    if (near) begin
      // keep the pair close so both answers come up often
      t.x1 = $signed(13'($urandom_range(6000))) - 13'sd3000;
      t.y1 = $signed(13'($urandom_range(6000))) - 13'sd3000;
      t.x2 = t.x1 + $signed(13'($urandom_range(1200))) - 13'sd600;
      t.y2 = t.y1 + $signed(13'($urandom_range(1200))) - 13'sd600;
      if (mode == 3) t.w1 = '0;
      if (mode == 4) t.h2 = '0;
      if (mode == 7) t.a1 = 16'($urandom_range(3)) * 16'd90;
    end
    return t;
  endfunction

  function automatic rect_pair_t mk(int x1, int y1, int w1, int h1, int a1,
                                    int x2, int y2, int w2, int h2, int a2);
    rect_pair_t t;
    t.x1 = COORD_BITS'(x1); t.y1 = COORD_BITS'(y1);
    t.w1 = SIZE_BITS'(w1); t.h1 = SIZE_BITS'(h1); t.a1 = ANGLE_BITS'(a1);
    t.x2 = COORD_BITS'(x2); t.y2 = COORD_BITS'(y2);
    t.w2 = SIZE_BITS'(w2); t.h2 = SIZE_BITS'(h2); t.a2 = ANGLE_BITS'(a2);
    return t;
  endfunction

  // sender
  initial begin
    board = new();
    gaps_on = 1;
    sending_done = 0;
    rst <= 1;
    in_valid <= 0;
    first_x <= 0; first_y <= 0; second_x <= 0; second_y <= 0;
    first_width <= 0; first_height <= 0; second_width <= 0; second_height <= 0;
    first_angle <= 0; second_angle <= 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed: touching edges, zero sizes, extremes, large angles
    stim.push_back(mk(0, 0, 10, 10, 0, 10, 0, 10, 10, 0));
    stim.push_back(mk(0, 0, 10, 10, 0, 11, 0, 10, 10, 0));
    stim.push_back(mk(0, 0, 10, 10, 0, 0, 10, 10, 10, 0));
    stim.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    stim.push_back(mk(0, 0, 0, 20, 45, 5, 5, 20, 0, 90));
    stim.push_back(mk(-4096, -4096, 1023, 1023, 0, 4095, 4095, 1023, 1023, 0));
    stim.push_back(mk(4095, 4095, 1023, 1023, 65535, -4096, -4096, 1023, 1023, 65535));
    stim.push_back(mk(-4096, -4096, 1023, 1023, 359, -4096, -4096, 1023, 1023, 360));
    stim.push_back(mk(0, 0, 100, 20, 45, 80, 80, 100, 20, 135));
    stim.push_back(mk(0, 0, 100, 20, 90, 0, 0, 100, 20, 180));
    stim.push_back(mk(0, 0, 100, 20, 270, 50, 50, 1, 1, 65400));
    stim.push_back(mk(0, 0, 1023, 1, 30, 400, 300, 1, 1023, 300));
    stim.push_back(mk(100, 100, 50, 50, 45, 160, 100, 50, 50, 45));
    stim.push_back(mk(0, 0, 682, 341, 21845, 0, 0, 341, 682, 43690));
    stim.push_back(mk(-1, -1, 1, 1, 0, 0, 0, 1, 1, 0));
    stim.push_back(mk(4095, -4096, 0, 1023, 180, -4096, 4095, 1023, 0, 270));
    foreach (stim[i]) send_pair(stim[i]);
    for (int i = 0; i < 1500; i++) begin
      gaps_on = !(i >= 300 && i < 600);
      send_pair(rand_pair($urandom_range(9) < 8));
    end
    in_valid <= 0;
    sending_done = 1;
  end

  // receiver, with one long hold-off
  initial begin
    int stall_left;
    bit stall_done;
    stall_left = 0;
    stall_done = 0;
    out_ready <= 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (board.checked >= 700 && !stall_done) begin
        stall_left = 60;
        stall_done = 1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 0;
      end else if (!gaps_on) out_ready <= 1;
      else out_ready <= ($urandom_range(99) >= 14);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_flag(overlap);
  end

  // end of run and watchdog
  initial begin
    fork
      begin
        wait (sending_done && board.pending.size() == 0);
        repeat (20) @(posedge clk);
        $display("checked %0d rectangle pair tests, %0d reported overlapping",
                 board.checked, board.hits);
        if (board.errors == 0 && board.pending.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
      end
      begin
        wait (cycles >= 200000);
        $display("timeout waiting for results");
        $display("simulation failed");
        $finish;
      end
    join
  end

  initial begin
    for (int k = 0; k < 91; k++) quarter_sine[k] = qsine(k);
  end

endmodule

/* oriented_rect_overlap_test.f */
rtl/orl_pkg.sv
rtl/orl_sincos.sv
rtl/oriented_rect_overlap_test.sv
rtl/orl_checker.sv
tb/sv/tb.sv
